### hw/rtl/bus_pair_change_monitor_unit_defines.svh
// Assertion macros used by the checker file of the bus pair change monitor.
`ifndef BUS_PAIR_CHANGE_MONITOR_UNIT_DEFINES_SVH
`define BUS_PAIR_CHANGE_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BPCM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BPCM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bpcm_pkg.sv
// Types, codes and helper functions of the bus pair change monitor.
package bpcm_pkg;

  localparam int unsigned STATUS_CHANNEL = 15;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    VIEW_BUS0 = 2'd0,
    VIEW_BUS1 = 2'd1,
    VIEW_BOTH = 2'd2,
    VIEW_NONE = 2'd3
  } view_mode_e;

  typedef enum logic [1:0] {
    STATUS_IDLE  = 2'd0,
    STATUS_OK    = 2'd1,
    STATUS_ERROR = 2'd2,
    STATUS_BUSY  = 2'd3
  } status_e;

  // One complete address/data pair on its way from the front to the back end.
  typedef struct packed {
    logic       bus;
    logic [6:0] channel;
    logic [7:0] data;
  } pair_t;

  function automatic status_e decode_status(input logic [7:0] data);
    status_e code;
    code = STATUS_IDLE;
    if (data == 8'(STATUS_OK)) code = STATUS_OK;
    else if (data == 8'(STATUS_ERROR)) code = STATUS_ERROR;
    else if (data == 8'(STATUS_BUSY)) code = STATUS_BUSY;
    return code;
  endfunction

endpackage

### hw/rtl/bpcm_in_if.sv
// Input channel: one received monitor byte per transfer.
interface bpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/bpcm_out_if.sv
// Output channel: one change or status report per transfer.
interface bpcm_out_if;
  logic       valid;
  logic       ready;
  logic       bus_id;
  logic [6:0] channel;
  logic [7:0] new_value;
  logic [7:0] old_value;
  logic       old_known;
  logic       value_changed;
  logic       shown;
  logic       status_valid;
  logic [1:0] status_code;

  modport source (
    output valid, output bus_id, output channel, output new_value, output old_value,
    output old_known, output value_changed, output shown, output status_valid,
    output status_code, input ready
  );
  modport sink (
    input valid, input bus_id, input channel, input new_value, input old_value,
    input old_known, input value_changed, input shown, input status_valid,
    input status_code, output ready
  );
endinterface

### hw/rtl/bpcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 112,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bpcm_front.sv
// Front end: pairs incoming bytes and drops pairs whose channel is out of range.
module bpcm_front import bpcm_pkg::*; #(
  parameter int unsigned CHANNELS = 112
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpcm_in_if.sink    in_ch,
  output logic       push_o,
  output pair_t      push_pair_o,
  input  logic       full_i
);

  logic       half_q;
  logic [7:0] addr_q;
  logic       accept;
  logic       in_range;

  // An address byte never needs queue space, so only the data byte waits on it.
  assign in_ch.ready = !half_q || !full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = {1'b0, addr_q[6:0]} < 8'(CHANNELS);

  assign push_o      = accept && half_q && in_range;
  assign push_pair_o = '{bus: addr_q[7], channel: addr_q[6:0], data: in_ch.rx_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
    end else if (accept) begin
      half_q <= !half_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !half_q) begin
      addr_q <= in_ch.rx_byte;
    end
  end

endmodule

### hw/rtl/bpcm_queue.sv
// Short queue of complete pairs between the front and back ends.
module bpcm_queue import bpcm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  pair_t pair_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output pair_t head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pair_t            entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    nxt = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    return nxt;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= pair_i;
    end
  end

endmodule

### hw/rtl/bpcm_back.sv
// Back end: shadow table lookup and update, change detection and the result register.
module bpcm_back import bpcm_pkg::*; #(
  parameter int unsigned CHANNELS = 112
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       q_valid_i,
  input  pair_t      q_pair_i,
  output logic       q_pop_o,
  bpcm_out_if.source out_ch
);

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  view_mode_e    view_mode_q;
  logic          b_valid_q;
  pair_t         b_pair_q;
  logic [CHANNELS-1:0] known0_q, known1_q;
  logic          fwd_valid_q;
  logic          fwd_bus_q;
  logic [IW-1:0] fwd_idx_q;
  logic [7:0]    fwd_data_q;

  logic          out_valid_q;
  logic          bus_id_q, old_known_q, value_changed_q, shown_q, status_valid_q;
  logic [6:0]    channel_q;
  logic [7:0]    new_value_q, old_value_q;
  status_e       status_code_q;

  logic [IW-1:0] idx;
  logic [7:0]    rd0, rd1, stored, old_val;
  logic          known, fwd_hit, changed, is_status, has_result, selected;
  logic          b_fire, b_accept, wr0, wr1;

  assign b_fire   = b_valid_q && (!out_valid_q || out_ch.ready);
  assign b_accept = !b_valid_q || b_fire;
  assign q_pop_o  = q_valid_i && b_accept;

  assign idx       = b_pair_q.channel[IW-1:0];
  assign known     = b_pair_q.bus ? known1_q[idx] : known0_q[idx];
  // The RAM read issued in the cycle of a write to the same entry sees old data.
  assign fwd_hit   = fwd_valid_q && (fwd_bus_q == b_pair_q.bus) && (fwd_idx_q == idx);
  assign stored    = fwd_hit ? fwd_data_q : (b_pair_q.bus ? rd1 : rd0);
  assign old_val   = known ? stored : '0;
  assign changed   = !known || (stored != b_pair_q.data);
  assign is_status = b_pair_q.channel == 7'(STATUS_CHANNEL);
  assign has_result = changed || is_status;

  assign wr0 = b_fire && changed && !b_pair_q.bus;
  assign wr1 = b_fire && changed && b_pair_q.bus;

  always_comb begin
    unique case (view_mode_q)
      VIEW_BUS0: selected = !b_pair_q.bus;
      VIEW_BUS1: selected = b_pair_q.bus;
      VIEW_BOTH: selected = 1'b1;
      VIEW_NONE: selected = 1'b0;
    endcase
  end

  bpcm_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_shadow0 (
    .clk_i   (clk_i),
    .we_i    (wr0),
    .waddr_i (idx),
    .wdata_i (b_pair_q.data),
    .re_i    (q_pop_o),
    .raddr_i (q_pair_i.channel[IW-1:0]),
    .rdata_o (rd0)
  );

  bpcm_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_shadow1 (
    .clk_i   (clk_i),
    .we_i    (wr1),
    .waddr_i (idx),
    .wdata_i (b_pair_q.data),
    .re_i    (q_pop_o),
    .raddr_i (q_pair_i.channel[IW-1:0]),
    .rdata_o (rd1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_mode_q <= VIEW_BUS0;
      b_valid_q   <= 1'b0;
      known0_q    <= '0;
      known1_q    <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) view_mode_q <= view_mode_e'(cfg_wdata_i);
      if (b_accept) b_valid_q <= q_valid_i;
      if (wr0) known0_q[idx] <= 1'b1;
      if (wr1) known1_q[idx] <= 1'b1;
      if (b_fire) fwd_valid_q <= changed;
      if (b_fire && has_result) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_pair_q <= q_pair_i;
    end
    if (b_fire && changed) begin
      fwd_bus_q  <= b_pair_q.bus;
      fwd_idx_q  <= idx;
      fwd_data_q <= b_pair_q.data;
    end
    if (b_fire && has_result) begin
      bus_id_q        <= b_pair_q.bus;
      channel_q       <= b_pair_q.channel;
      new_value_q     <= b_pair_q.data;
      old_value_q     <= old_val;
      old_known_q     <= known;
      value_changed_q <= changed;
      shown_q         <= changed && selected;
      status_valid_q  <= is_status;
      status_code_q   <= is_status ? decode_status(b_pair_q.data) : STATUS_IDLE;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.bus_id        = bus_id_q;
  assign out_ch.channel       = channel_q;
  assign out_ch.new_value     = new_value_q;
  assign out_ch.old_value     = old_value_q;
  assign out_ch.old_known     = old_known_q;
  assign out_ch.value_changed = value_changed_q;
  assign out_ch.shown         = shown_q;
  assign out_ch.status_valid  = status_valid_q;
  assign out_ch.status_code   = status_code_q;

endmodule

### hw/rtl/bus_pair_change_monitor_unit.sv
// Top level of the bus pair change monitor.
// Bytes from the monitor link enter on in_ch, alternately an address byte
// (bit 7 bus, bits 6..0 channel) and a data byte. Each complete pair is
// checked against a per-bus shadow table; a report leaves on out_ch when the
// value changed or the channel is the status channel. Pairs whose channel is
// CHANNELS or above are dropped. cfg_we_i/cfg_wdata_i write the view mode,
// which sets the shown flag of each report.
// Throughput is one byte per cycle while in_ch.ready is high. Each pair
// passes the pair queue and the registered shadow RAM read; the compare and
// table write then happen as the report is loaded into the output register.
// Reset clears the byte pairing, the queue, the known flags of both tables
// and the view mode; no clearing pass is needed.
// When the receiver stalls, the held report stays in the output register,
// the back end holds one pair, the two-entry queue fills, and in_ch.ready
// drops only on a data byte that finds the queue full.
module bus_pair_change_monitor_unit import bpcm_pkg::*; #(
  parameter int unsigned CHANNELS = 112
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpcm_in_if.sink    in_ch,
  bpcm_out_if.source out_ch,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  logic  push, full, q_valid, q_pop;
  pair_t push_pair, q_head;

  bpcm_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .push_o      (push),
    .push_pair_o (push_pair),
    .full_i      (full)
  );

  bpcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pair_i  (push_pair),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  bpcm_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_pair_i    (q_head),
    .q_pop_o     (q_pop),
    .out_ch      (out_ch)
  );

endmodule

### hw/rtl/bpcm_checker.sv
// Port-level checker of the bus pair change monitor and its bind.
`include "bus_pair_change_monitor_unit_defines.svh"

module bpcm_checker import bpcm_pkg::*; #(
  parameter int unsigned CHANNELS = 112
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] channel,
  input logic [7:0] new_value,
  input logic [7:0] old_value,
  input logic       old_known,
  input logic       value_changed,
  input logic       shown,
  input logic       status_valid,
  input logic [1:0] status_code
);

  // A stalled report must not be dropped or altered.
  `BPCM_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(new_value), "report changed while stalled")

  // A report without a change is only given for a known status channel with equal value, and is not shown.
  `BPCM_ASSERT_IMP(a_unchanged_status, out_valid && !value_changed, status_valid && old_known && (old_value == new_value) && !shown, "unchanged report outside status channel")

  // An unknown entry always counts as a change and reads as zero.
  `BPCM_ASSERT_IMP(a_unknown_old, out_valid && !old_known, value_changed && (old_value == 8'd0), "unknown entry reported wrongly")

  // The status flag follows the channel, and the code is idle elsewhere.
  `BPCM_ASSERT_IMP(a_status_chan, out_valid, (status_valid == (channel == 7'(STATUS_CHANNEL))) && (status_valid || (status_code == STATUS_IDLE)), "status flag or code wrong")

  // No report is ever given for a dropped channel.
  `BPCM_ASSERT_IMP(a_chan_range, out_valid, int'(channel) < int'(CHANNELS), "report for out-of-range channel")

endmodule

bind bus_pair_change_monitor_unit bpcm_checker #(.CHANNELS(CHANNELS)) u_bpcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .channel       (out_ch.channel),
  .new_value     (out_ch.new_value),
  .old_value     (out_ch.old_value),
  .old_known     (out_ch.old_known),
  .value_changed (out_ch.value_changed),
  .shown         (out_ch.shown),
  .status_valid  (out_ch.status_valid),
  .status_code   (out_ch.status_code)
);
